@@ design/bpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and helpers of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int ADDR_W             = 22;
   localparam int MAP_WORD_W         = 32;
   localparam int BIT_SEL_W          = 5;
   localparam int DEFAULT_PAGE_COUNT = 1024;
   localparam int DEFAULT_PAGE_BYTES = 4096;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [1:0] STATUS_OUT_RANGE = 2'd2;

   typedef struct packed {
      logic              op;
      logic [ADDR_W-1:0] free_addr;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_addr;
      logic [1:0]        status;
   } rsp_type;

   // Returns {found, position} of the lowest clear bit of a map word.
   function automatic logic [BIT_SEL_W:0] first_zero(input logic [MAP_WORD_W-1:0] w);
      logic [BIT_SEL_W-1:0] pos;
      pos = '0;
      for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            pos = BIT_SEL_W'(i);
         end
      end
      return {~(&w), pos};
   endfunction

endpackage

@@ design/bpa_map_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_map_ram
// Used-bit map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpa_map_ram
   import bpa_pkg::*;
#(
   parameter int DEPTH  = DEFAULT_PAGE_COUNT / MAP_WORD_W,
   parameter int ADDR_B = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_B-1:0]     wr_addr,
   input  logic [MAP_WORD_W-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_B-1:0]     rd_addr,
   output logic [MAP_WORD_W-1:0] rd_data
);

   logic [MAP_WORD_W-1:0] mem [DEPTH];
   logic [MAP_WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bpa_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_divider
// Division of a byte address by the page size through a fixed reciprocal.
// ----------------------------------------------------------------------------
module bpa_divider
   import bpa_pkg::*;
#(
   parameter int PAGE_BYTES = DEFAULT_PAGE_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] dividend,
   output logic              done,
   output logic [ADDR_W-1:0] quotient
);

   localparam int SHIFT_B = $clog2(PAGE_BYTES);
   localparam int FRAC_W  = ADDR_W + SHIFT_B;
   localparam int RECIP_W = ADDR_W + 1;
   localparam int PROD_W  = ADDR_W + RECIP_W;
   localparam longint RECIP_L =
      ((longint'(1) << FRAC_W) + longint'(PAGE_BYTES) - 1) / longint'(PAGE_BYTES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   logic              done_ff, done_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // The reciprocal is rounded up, which keeps the truncated quotient exact
   // for every address that fits in the field.
   always_comb begin
      done_in = start;
      prod_in = prod_ff;
      if (start) begin
         prod_in = PROD_W'(dividend) * PROD_W'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
   end

   assign done     = done_ff;
   assign quotient = ADDR_W'(prod_ff >> FRAC_W);

endmodule

@@ design/bitmap_page_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Physical page frame allocator over a used-bit map held in a RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the map RAM to zero, one 32-bit word per cycle
// (PAGE_COUNT/32 words, rounded up), and takes no request meanwhile. A request
// is then handled alone. An allocate scans the map one word per cycle through
// the RAM read port and stops at the first word that holds a free page, so it
// is done sooner when a free page sits low in the map. A free turns the
// address into a page index with one multiply by the reciprocal of the page
// size, then does a read-modify-write of one map word, unless the page lies
// beyond the map. The result sits in an output register, so a new request is
// taken while it waits to be collected.
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int PAGE_COUNT = DEFAULT_PAGE_COUNT,
   parameter int PAGE_BYTES = DEFAULT_PAGE_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int MAP_WORDS = (PAGE_COUNT + MAP_WORD_W - 1) / MAP_WORD_W;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IDX_W     = WORD_AW + BIT_SEL_W;
   localparam int PROD_W    = IDX_W + $clog2(PAGE_BYTES) + 1;
   localparam int CMP_W     = ADDR_W + 1;
   localparam int LAST_BITS = PAGE_COUNT - MAP_WORD_W * (MAP_WORDS - 1);

   localparam logic [WORD_AW-1:0]    LAST_WORD = WORD_AW'(MAP_WORDS - 1);
   localparam logic [MAP_WORD_W-1:0] LAST_PAD  =
      MAP_WORD_W'(~((64'd1 << LAST_BITS) - 64'd1));
   localparam logic [PROD_W-1:0]     PB_C      = PROD_W'(PAGE_BYTES);
   localparam logic [CMP_W-1:0]      PC_C      = CMP_W'(PAGE_COUNT);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_FREE  = 3'd5;
   localparam logic [2:0] ST_RESP  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [WORD_AW-1:0]    word_ff, word_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [ADDR_W-1:0]     res_addr_ff, res_addr_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  ram_we, ram_re;
   logic [WORD_AW-1:0]    ram_waddr, ram_raddr;
   logic [MAP_WORD_W-1:0] ram_wdata, ram_rdata;

   logic                  div_start, div_done;
   logic [ADDR_W-1:0]     div_quot;

   logic [MAP_WORD_W-1:0] scan_word;
   logic [BIT_SEL_W:0]    zero_hit;
   logic [PROD_W-1:0]     product;

   bpa_map_ram #(
      .DEPTH  (MAP_WORDS),
      .ADDR_B (WORD_AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bpa_divider #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_data.free_addr),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Pad bits past the last page in the final word look used to the scan.
   assign scan_word = ram_rdata | ((word_ff == LAST_WORD) ? LAST_PAD : '0);
   assign zero_hit  = first_zero(scan_word);
   assign product   = PROD_W'(idx_ff) * PB_C;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      idx_in        = idx_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = word_ff;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = word_ff;
      div_start     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (word_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.op == OP_ALLOC) begin
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  word_in   = '0;
                  state_in  = ST_SCAN;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_SCAN: begin
            if (zero_hit[BIT_SEL_W]) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata | (MAP_WORD_W'(1) << zero_hit[BIT_SEL_W-1:0]);
               idx_in    = {word_ff, zero_hit[BIT_SEL_W-1:0]};
               state_in  = ST_MUL;
            end else if (word_ff == LAST_WORD) begin
               res_addr_in   = '0;
               res_status_in = STATUS_NO_FREE;
               state_in      = ST_RESP;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = word_ff + 1'b1;
               word_in   = word_ff + 1'b1;
            end
         end
         ST_MUL: begin
            res_addr_in   = ADDR_W'(product);
            res_status_in = STATUS_DONE;
            state_in      = ST_RESP;
         end
         ST_DIV: begin
            if (div_done) begin
               if (CMP_W'(div_quot) >= PC_C) begin
                  res_addr_in   = '0;
                  res_status_in = STATUS_OUT_RANGE;
                  state_in      = ST_RESP;
               end else begin
                  idx_in    = div_quot[IDX_W-1:0];
                  ram_re    = 1'b1;
                  ram_raddr = div_quot[IDX_W-1:BIT_SEL_W];
                  state_in  = ST_FREE;
               end
            end
         end
         ST_FREE: begin
            ram_we        = 1'b1;
            ram_waddr     = idx_ff[IDX_W-1:BIT_SEL_W];
            ram_wdata     = ram_rdata & ~(MAP_WORD_W'(1) << idx_ff[BIT_SEL_W-1:0]);
            res_addr_in   = '0;
            res_status_in = STATUS_DONE;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_addr = res_addr_ff;
               rsp_data_in.status      = res_status_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted request always moves the sequencer out of idle.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after accepting a request");

   // A free only touches the map for a page inside it.
   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FREE) |-> (CMP_W'(idx_ff) < PC_C))
      else $error("free write to a page outside the map");

   // No request and no result while the map is being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!req_ready && !rsp_valid))
      else $error("handshake active during the clearing pass");

   // A result is loaded only from the response state.
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_RESP))
      else $error("result loaded outside the response state");

endmodule
